// File: hdl/rbfi_pkg.sv
// Shared types and constants of the random bit flip injector.
// No dependencies; every other file of the block imports this package.
package rbfi_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned PairW    = 2 * WordW;
  localparam int unsigned CountW   = 5;
  localparam int unsigned PosW     = 7;
  localparam int unsigned SeedW    = 31;
  localparam int unsigned MultW    = 15;
  localparam int unsigned ProdW    = SeedW + MultW;
  localparam int unsigned SumW     = SeedW + 1;
  localparam int unsigned LowBits  = 3;
  localparam int unsigned QuotW    = SeedW - LowBits;
  localparam int unsigned StepBits = 4;
  localparam int unsigned Groups   = QuotW / StepBits;
  localparam int unsigned GrpCntW  = $clog2(Groups);
  localparam int unsigned RemW     = 4;

  localparam logic [MultW-1:0]  PmMult   = 15'd16807;
  localparam logic [SeedW-1:0]  PmMod    = 31'h7fffffff;
  localparam logic [SeedW-1:0]  SeedInit = 31'd1;
  localparam logic [CountW-1:0] MaxBytes = 5'd16;

  // Generator sequencing strobes.
  typedef struct packed {
    logic mul_en;
    logic fold_en;
  } pm_ctrl_t;

  // Remainder unit status toward the sequencer.
  typedef struct packed {
    logic            done;
    logic [RemW-1:0] rem;
  } rem_res_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_FOLD  = 6'b000100,
    S_START = 6'b001000,
    S_WAIT  = 6'b010000,
    S_HOLD  = 6'b100000
  } state_e;

endpackage

// File: hdl/rbfi_in_if.sv
// Input channel of the injector: valid/ready plus word halves and byte count.
// Depends on rbfi_pkg for field widths.
interface rbfi_in_if;
  import rbfi_pkg::*;

  logic              valid;
  logic              ready;
  logic [WordW-1:0]  word_low;
  logic [WordW-1:0]  word_high;
  logic [CountW-1:0] byte_count;

  modport source (output valid, word_low, word_high, byte_count, input ready);
  modport sink   (input valid, word_low, word_high, byte_count, output ready);
endinterface

// File: hdl/rbfi_out_if.sv
// Result channel of the injector: valid/ready plus flipped word and position.
// Depends on rbfi_pkg for field widths.
interface rbfi_out_if;
  import rbfi_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] out_low;
  logic [WordW-1:0] out_high;
  logic [PosW-1:0]  flip_position;

  modport source (output valid, out_low, out_high, flip_position, input ready);
  modport sink   (input valid, out_low, out_high, flip_position, output ready);
endinterface

// File: hdl/rbfi_pm_gen.sv
// Minimal-standard generator: registered 31x15 multiply, then a fold by 2^31 - 1.
// Depends on rbfi_pkg.
module rbfi_pm_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbfi_pkg::SeedW-1:0] cfg_wdata_i,
  input  rbfi_pkg::pm_ctrl_t         ctrl_i,
  output logic [rbfi_pkg::SeedW-1:0] value_o
);
  import rbfi_pkg::*;

  logic [SeedW-1:0] gen_q, gen_d;
  logic [ProdW-1:0] prod_q;
  logic [SumW-1:0]  sum;

  // 2^31 = 1 mod (2^31 - 1): add the high part onto the low part, one correction.
  always_comb begin
    sum   = SumW'(prod_q[SeedW-1:0]) + SumW'(prod_q[ProdW-1:SeedW]);
    gen_d = gen_q;
    if (cfg_we_i) begin
      gen_d = cfg_wdata_i;
    end else if (ctrl_i.fold_en) begin
      if (sum == '0) begin
        gen_d = PmMod;
      end else if (sum > SumW'(PmMod)) begin
        gen_d = SeedW'(sum - SumW'(PmMod));
      end else begin
        gen_d = sum[SeedW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= SeedInit;
    end else begin
      gen_q <= gen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ProdW'(gen_q) * ProdW'(PmMult);
    end
  end

  assign value_o = gen_q;
endmodule

// File: hdl/rbfi_rem_unit.sv
// Iterative remainder unit: dividend mod a 1..16 divisor, four bits per cycle.
// Depends on rbfi_pkg.
module rbfi_rem_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rbfi_pkg::QuotW-1:0]  dividend_i,
  input  logic [rbfi_pkg::CountW-1:0] divisor_i,
  output rbfi_pkg::rem_res_t          res_o
);
  import rbfi_pkg::*;

  logic               busy_q, done_q;
  logic [GrpCntW-1:0] cnt_q;
  logic [QuotW-1:0]   quot_q;
  logic [CountW-1:0]  div_q;
  logic [RemW-1:0]    rem_q, rem_next;

  // Restoring steps: shift one dividend bit in, subtract when it fits.
  always_comb begin
    logic [RemW:0]   trial;
    logic [RemW-1:0] part;
    part = rem_q;
    for (int i = 0; i < StepBits; i++) begin
      trial = {part, quot_q[QuotW-1-i]};
      if (trial >= div_q) begin
        trial = trial - div_q;
      end
      part = trial[RemW-1:0];
    end
    rem_next = part;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= GrpCntW'(Groups - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      quot_q <= {quot_q[QuotW-StepBits-1:0], {StepBits{1'b0}}};
      rem_q  <= rem_next;
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q;
endmodule

// File: hdl/random_bit_flip_injector_top.sv
// Random bit flip injector. Each accepted transaction carries a 128-bit word
// (word_low, word_high) and a byte count of 1 to 16; the block advances a
// minimal-standard generator (x * 16807 mod 2^31 - 1, zero replaced by 2^31 - 1),
// picks a bit position as the new value mod 8 * byte_count, flips that bit and
// returns the word with the position. A byte count of 0 or above 16 acts as 16.
// A write on cfg_we_i/cfg_wdata_i reloads the generator with the seed; reset
// loads 1. Write the seed only while no transaction is in flight. From
// acceptance to the result register a transaction passes the multiply,
// the fold, the divider load, the passes of the remainder unit, which
// retires four quotient bits per cycle, a state that acts on the divider's
// done flag and the hand-off. in_if.ready rises again as the result is
// loaded, so a transaction is accepted only after the previous one is
// handed off; a new one can enter while the previous result still waits for
// out_if.ready; the hand-off holds while an earlier result is still unread.
module random_bit_flip_injector_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbfi_pkg::SeedW-1:0] cfg_wdata_i,
  rbfi_in_if.sink                    in_if,
  rbfi_out_if.source                 out_if
);
  import rbfi_pkg::*;

  state_e            state_q, state_d;
  pm_ctrl_t          pm_ctrl;
  rem_res_t          rem_res;
  logic [SeedW-1:0]  gen_value;
  logic [PairW-1:0]  word_q;
  logic [CountW-1:0] count_q;
  logic              rem_start;
  logic              out_valid_q;
  logic              load_out;
  logic [PosW-1:0]   pos;
  logic [PairW-1:0]  flipped;
  logic [WordW-1:0]  out_low_q, out_high_q;
  logic [PosW-1:0]   out_pos_q;
  logic              in_accept;

  assign in_accept  = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);

  // Sequencer: multiply, fold, start divider, wait, then hand off the result.
  always_comb begin
    state_d         = state_q;
    pm_ctrl.mul_en  = 1'b0;
    pm_ctrl.fold_en = 1'b0;
    rem_start       = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        pm_ctrl.mul_en = 1'b1;
        state_d        = S_FOLD;
      end
      S_FOLD: begin
        pm_ctrl.fold_en = 1'b1;
        state_d         = S_START;
      end
      S_START: begin
        rem_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (rem_res.done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        // Hold until the result register is free.
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the word and the normalized byte count on acceptance.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      word_q <= {in_if.word_high, in_if.word_low};
      if ((in_if.byte_count == '0) || (in_if.byte_count > MaxBytes)) begin
        count_q <= MaxBytes;
      end else begin
        count_q <= in_if.byte_count;
      end
    end
  end

  rbfi_pm_gen u_pm_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (pm_ctrl),
    .value_o     (gen_value)
  );

  // value mod 8c = 8 * ((value >> 3) mod c) + value[2:0].
  rbfi_rem_unit u_rem_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (gen_value[SeedW-1:LowBits]),
    .divisor_i  (count_q),
    .res_o      (rem_res)
  );

  assign pos     = {rem_res.rem, gen_value[LowBits-1:0]};
  assign flipped = word_q ^ (PairW'(1) << pos);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_low_q  <= flipped[WordW-1:0];
      out_high_q <= flipped[PairW-1:WordW];
      out_pos_q  <= pos;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.out_low       = out_low_q;
  assign out_if.out_high      = out_high_q;
  assign out_if.flip_position = out_pos_q;
endmodule

// File: hdl/rbfi_checker.sv
// Port-level checks of the injector, attached to the top level by bind.
// Depends on rbfi_pkg and random_bit_flip_injector_top.
module rbfi_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rbfi_pkg::WordW-1:0] out_low_i,
  input logic [rbfi_pkg::PosW-1:0]  flip_position_i
);
  import rbfi_pkg::*;

  // A pending result stays offered until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped before acceptance");

  // Busy after acceptance.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken again while busy");

  // A fresh result appears together with the block going idle.
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $rose(in_ready_i))
    else $error("result appeared outside hand-off");

  // Acceptance does not disturb out_low or flip_position of the result register.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> ($stable(out_low_i) && $stable(flip_position_i)))
    else $error("result changed right after acceptance");
endmodule

bind random_bit_flip_injector_top rbfi_checker u_rbfi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_low_i       (out_if.out_low),
  .flip_position_i (out_if.flip_position)
);

// File: verif/tb_random_bit_flip_injector_top.sv
// Self-checking testbench for random_bit_flip_injector_top: queue-fed driver,
// clocked monitor and an in-bench generator/bit-flip predictor.
// Depends on rbfi_pkg, rbfi_in_if, rbfi_out_if and the injector top level.
module tb_random_bit_flip_injector_top;
  import rbfi_pkg::*;

  localparam int unsigned ClkHalf    = 5;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCyc  = 30;
  localparam int unsigned PhaseItems = 335;

  // One input transaction as the driver holds it.
  typedef struct {
    logic [WordW-1:0]  low;
    logic [WordW-1:0]  high;
    logic [CountW-1:0] count;
  } target_word_t;

  // One predicted result transaction.
  typedef struct {
    logic [WordW-1:0] low;
    logic [WordW-1:0] high;
    logic [PosW-1:0]  pos;
  } flipped_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [SeedW-1:0] cfg_wdata;

  rbfi_in_if  in_if ();
  rbfi_out_if out_if ();

  random_bit_flip_injector_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  target_word_t  pending_words[$];
  flipped_word_t expected_flips[$];
  target_word_t  next_word;

  // Predictor copy of the generator; reloaded on every seed write.
  logic [SeedW-1:0] gen_value;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count  = 0;
  int unsigned error_count  = 0;
  logic        quiet_window = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  // Advance the minimal-standard generator one step; zero maps to 2^31 - 1.
  function automatic logic [SeedW-1:0] pm_advance(input logic [SeedW-1:0] x);
    logic [ProdW-1:0] prod;
    logic [ProdW-1:0] rem;
    prod = x * PmMult;
    rem  = prod % PmMod;
    return (rem == '0) ? PmMod : rem[SeedW-1:0];
  endfunction

  // Pick the position from the new generator value and invert that bit.
  function automatic flipped_word_t flip_word(input target_word_t w,
                                              input logic [SeedW-1:0] g);
    flipped_word_t    r;
    logic [CountW-1:0] cnt;
    logic [7:0]        span;
    logic [PairW-1:0]  pair;
    logic [PosW-1:0]   pos;
    cnt  = (w.count == '0 || w.count > MaxBytes) ? MaxBytes : w.count;
    span = 8'(cnt) * 8'd8;
    pos  = PosW'(g % span);
    pair = {w.high, w.low} ^ (PairW'(1) << pos);
    r.low  = pair[WordW-1:0];
    r.high = pair[PairW-1:WordW];
    r.pos  = pos;
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic add_item(input logic [WordW-1:0] lo, input logic [WordW-1:0] hi,
                          input logic [CountW-1:0] cnt);
    target_word_t w;
    w.low   = lo;
    w.high  = hi;
    w.count = cnt;
    pending_words.push_back(w);
  endtask

  // Hold until every queued transaction is accepted and every result is back,
  // then let the block settle before anything touches the seed.
  task automatic drain_all();
    while (pending_words.size() != 0 || in_if.valid || expected_flips.size() != 0)
      @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Reload the seed at a rising edge; the driver reloads the predictor copy
  // at the same edge.
  task automatic write_seed(input logic [SeedW-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Cycle counter and watchdog. The counter also opens recurring windows with
  // no idling on either side, so that back-to-back stretches show up in
  // every phase.
  always @(posedge clk_i) begin
    cycle_count  <= cycle_count + 1;
    quiet_window <= ((cycle_count % 128) < 16);
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Driver: on a seed write reload the predictor; on acceptance, advance the
  // predictor and queue the expected result; when the slot is free, either
  // present the next pending item or drop valid.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid      <= 1'b0;
      in_if.word_low   <= '0;
      in_if.word_high  <= '0;
      in_if.byte_count <= '0;
      gen_value         = SeedInit;
    end else begin
      if (cfg_we) begin
        gen_value = cfg_wdata;
      end
      if (in_if.valid && in_if.ready) begin
        gen_value = pm_advance(gen_value);
        expected_flips.push_back(flip_word(next_word, gen_value));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_words.size() != 0 &&
            (quiet_window || $urandom_range(99) >= send_idle_pct)) begin
          next_word = pending_words.pop_front();
          in_if.valid      <= 1'b1;
          in_if.word_low   <= next_word.low;
          in_if.word_high  <= next_word.high;
          in_if.byte_count <= next_word.count;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation and
  // pick the next ready value at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_flips.size() == 0) begin
          flag_error($sformatf("unexpected result low=%h high=%h pos=%0d",
                               out_if.out_low, out_if.out_high, out_if.flip_position));
        end else begin
          if (out_if.out_low !== expected_flips[0].low)
            flag_error($sformatf("out_low got %h exp %h",
                                 out_if.out_low, expected_flips[0].low));
          if (out_if.out_high !== expected_flips[0].high)
            flag_error($sformatf("out_high got %h exp %h",
                                 out_if.out_high, expected_flips[0].high));
          if (out_if.flip_position !== expected_flips[0].pos)
            flag_error($sformatf("flip_position got %0d exp %0d",
                                 out_if.flip_position, expected_flips[0].pos));
          void'(expected_flips.pop_front());
        end
      end
      out_if.ready <= quiet_window || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    logic [WordW-1:0]  lo;
    logic [WordW-1:0]  hi;
    logic [CountW-1:0] cnt;
    int unsigned       roll;
    logic [SeedW-1:0]  phase_seed;

    // Drive reset and the seed port to a known value from time zero.
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset seed, every legal byte count, then zero and the
    // out-of-range counts that saturate to sixteen.
    for (int i = 1; i <= 16; i++) begin
      case (i % 4)
        0: add_item('0, '0, CountW'(i));
        1: add_item('1, '1, CountW'(i));
        2: add_item({WordW/4{4'ha}}, {WordW/4{4'h5}}, CountW'(i));
        default: add_item({WordW/4{4'h5}}, {WordW/4{4'ha}}, CountW'(i));
      endcase
    end
    add_item('1, '0, 5'd0);
    add_item('0, '1, 5'd17);
    add_item('1, '1, 5'd31);
    drain_all();

    // Seed of zero: the first step lands on 2^31 - 1.
    write_seed('0);
    add_item('0, '0, 5'd16);
    add_item('1, '1, 5'd7);
    drain_all();

    // Seed at 2^31 - 1: the generator stays on its fixed point.
    write_seed(PmMod);
    add_item('0, '0, 5'd16);
    add_item('0, '1, 5'd3);
    add_item('1, '0, 5'd12);
    drain_all();

    // Random phases, one idling pattern each, each with a fresh seed.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  phase_seed = SeedW'($urandom); end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  phase_seed = 31'h2aaaaaaa; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; phase_seed = 31'h55555555; end
        default: begin
          send_idle_pct = 38; recv_stall_pct = 38; phase_seed = SeedW'($urandom);
        end
      endcase
      write_seed(phase_seed);
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          lo = '0; hi = '0;
        end else if (roll < 10) begin
          lo = '1; hi = '1;
        end else begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
        // Mostly legal counts; the rest are zero or saturate above sixteen.
        roll = $urandom_range(99);
        if (roll < 85)      cnt = CountW'($urandom_range(16, 1));
        else if (roll < 90) cnt = '0;
        else                cnt = CountW'($urandom_range(31, 17));
        add_item(lo, hi, cnt);
      end
      drain_all();
    end

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: random_bit_flip_injector_top.f
hdl/rbfi_pkg.sv
hdl/rbfi_in_if.sv
hdl/rbfi_out_if.sv
hdl/rbfi_pm_gen.sv
hdl/rbfi_rem_unit.sv
hdl/random_bit_flip_injector_top.sv
hdl/rbfi_checker.sv
verif/tb_random_bit_flip_injector_top.sv
